// ----- rtl/core/pdoc_pkg.sv -----
package pdoc_pkg;

  localparam int unsigned HIST_DEPTH = 2048;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = HIST_AW + 1;

  localparam logic [7:0] LIT_RUN_MAX  = 8'h08;
  localparam logic [7:0] PLAIN_MAX    = 8'h7F;
  localparam logic [7:0] SPACE_PAIR_LO = 8'hC0;
  localparam logic [7:0] FLIP_MASK    = 8'h80;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [13:0] CODE_MASK   = 14'h3FFF;
  localparam logic [3:0] LEN_BIAS     = 4'd3;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIST  = 2'd1,
    ERR_TRUNC = 2'd2
  } err_e_t;

  typedef enum logic [1:0] {
    TOK_IDLE = 2'd0,
    TOK_LIT  = 2'd1,
    TOK_PAIR = 2'd2
  } tok_mode_t;

  typedef enum logic [3:0] {
    ST_ACCEPT = 4'b0001,
    ST_LIT2   = 4'b0010,
    ST_COPY   = 4'b0100,
    ST_TRUNC  = 4'b1000
  } dec_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       record_end;
    logic [1:0] error;
  } out_beat_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [7:0]         data;
  } hist_wr_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
  } hist_rd_t;

endpackage

// ----- rtl/core/pdoc_hist_ram.sv -----
module pdoc_hist_ram #(
  parameter int unsigned AW = 11,
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pdoc_decoder.sv -----
module pdoc_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdoc_pkg::in_beat_t  in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output pdoc_pkg::out_beat_t res_data,
  output pdoc_pkg::hist_wr_t  hist_wr,
  output pdoc_pkg::hist_rd_t  hist_rd,
  input  logic [7:0]          hist_rdata
);

  pdoc_pkg::dec_state_t state_r, state_nxt;
  pdoc_pkg::tok_mode_t  tok_r, tok_nxt;
  logic [3:0]                   lit_left_r, lit_left_nxt;
  logic [5:0]                   pair_hi_r, pair_hi_nxt;
  logic [pdoc_pkg::HIST_AW-1:0] wptr_r, wptr_nxt;
  logic [pdoc_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [3:0]                   copy_left_r, copy_left_nxt;
  logic                         last_r, last_nxt;
  logic [pdoc_pkg::HIST_AW-1:0] src_r, src_nxt;
  logic [7:0]                   hold_r, hold_nxt;
  logic                         byp_r;
  logic [7:0]                   byp_data_r;

  logic                         acc;
  logic                         dec_push;
  logic                         clear;
  logic [13:0]                  code;
  logic [pdoc_pkg::HIST_AW-1:0] back_dist;
  logic [3:0]                   len;
  logic                         dist_bad;
  logic [7:0]                   ram_byte;
  logic [7:0]                   c;

  assign c         = in_data.in_byte;
  assign code      = {pair_hi_r, c} & pdoc_pkg::CODE_MASK;
  assign back_dist = code[13:3];
  assign len       = {1'b0, code[2:0]} + pdoc_pkg::LEN_BIAS;
  assign dist_bad  = (back_dist == '0) || ({1'b0, back_dist} > count_r);
  assign ram_byte  = byp_r ? byp_data_r : hist_rdata;
  assign in_ready  = (state_r == pdoc_pkg::ST_ACCEPT) && res_ready;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    lit_left_nxt  = lit_left_r;
    pair_hi_nxt   = pair_hi_r;
    copy_left_nxt = copy_left_r;
    last_nxt      = last_r;
    src_nxt       = src_r;
    hold_nxt      = hold_r;
    res_valid     = 1'b0;
    res_data      = '0;
    dec_push      = 1'b0;
    clear         = 1'b0;
    hist_rd.en    = 1'b0;
    hist_rd.addr  = src_r;

    unique case (state_r)
      pdoc_pkg::ST_ACCEPT: begin
        if (acc) begin
          last_nxt = in_data.last_in;
          unique case (tok_r)
            pdoc_pkg::TOK_LIT: begin
              res_valid         = 1'b1;
              res_data.out_byte = c;
              dec_push          = 1'b1;
              lit_left_nxt      = lit_left_r - 4'd1;
              if (lit_left_r == 4'd1) begin
                tok_nxt             = pdoc_pkg::TOK_IDLE;
                res_data.run_last   = 1'b1;
                res_data.record_end = in_data.last_in;
                clear               = in_data.last_in;
              end else if (in_data.last_in) begin
                state_nxt = pdoc_pkg::ST_TRUNC;
              end else begin
                res_data.run_last = 1'b1;
              end
            end
            pdoc_pkg::TOK_PAIR: begin
              tok_nxt     = pdoc_pkg::TOK_IDLE;
              pair_hi_nxt = '0;
              if (dist_bad) begin
                res_valid           = 1'b1;
                res_data.error      = pdoc_pkg::ERR_DIST;
                res_data.run_last   = 1'b1;
                res_data.record_end = in_data.last_in;
                clear               = in_data.last_in;
              end else begin
                hist_rd.en    = 1'b1;
                hist_rd.addr  = wptr_r - back_dist;
                src_nxt       = wptr_r - back_dist + 1'b1;
                copy_left_nxt = len;
                state_nxt     = pdoc_pkg::ST_COPY;
              end
            end
            default: begin
              if (c != 8'h00 && c <= pdoc_pkg::LIT_RUN_MAX) begin
                tok_nxt      = pdoc_pkg::TOK_LIT;
                lit_left_nxt = c[3:0];
                if (in_data.last_in) begin
                  state_nxt = pdoc_pkg::ST_TRUNC;
                end
              end else if (c <= pdoc_pkg::PLAIN_MAX) begin
                res_valid           = 1'b1;
                res_data.out_byte   = c;
                res_data.run_last   = 1'b1;
                res_data.record_end = in_data.last_in;
                dec_push            = 1'b1;
                clear               = in_data.last_in;
              end else if (c >= pdoc_pkg::SPACE_PAIR_LO) begin
                res_valid         = 1'b1;
                res_data.out_byte = pdoc_pkg::SPACE_CHAR;
                dec_push          = 1'b1;
                hold_nxt          = c ^ pdoc_pkg::FLIP_MASK;
                state_nxt         = pdoc_pkg::ST_LIT2;
              end else begin
                tok_nxt     = pdoc_pkg::TOK_PAIR;
                pair_hi_nxt = c[5:0];
                if (in_data.last_in) begin
                  state_nxt = pdoc_pkg::ST_TRUNC;
                end
              end
            end
          endcase
        end
      end
      pdoc_pkg::ST_LIT2: begin
        if (res_ready) begin
          res_valid           = 1'b1;
          res_data.out_byte   = hold_r;
          res_data.run_last   = 1'b1;
          res_data.record_end = last_r;
          dec_push            = 1'b1;
          clear               = last_r;
          state_nxt           = pdoc_pkg::ST_ACCEPT;
        end
      end
      pdoc_pkg::ST_COPY: begin
        if (res_ready) begin
          res_valid         = 1'b1;
          res_data.out_byte = ram_byte;
          dec_push          = 1'b1;
          copy_left_nxt     = copy_left_r - 4'd1;
          if (copy_left_r == 4'd1) begin
            res_data.run_last   = 1'b1;
            res_data.record_end = last_r;
            clear               = last_r;
            state_nxt           = pdoc_pkg::ST_ACCEPT;
          end else begin
            hist_rd.en   = 1'b1;
            hist_rd.addr = src_r;
            src_nxt      = src_r + 1'b1;
          end
        end
      end
      pdoc_pkg::ST_TRUNC: begin
        if (res_ready) begin
          res_valid           = 1'b1;
          res_data.error      = pdoc_pkg::ERR_TRUNC;
          res_data.run_last   = 1'b1;
          res_data.record_end = 1'b1;
          clear               = 1'b1;
          state_nxt           = pdoc_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = pdoc_pkg::ST_ACCEPT;
      end
    endcase
  end

  assign hist_wr.en   = dec_push;
  assign hist_wr.addr = wptr_r;
  assign hist_wr.data = res_data.out_byte;

  always_comb begin
    wptr_nxt  = wptr_r;
    count_nxt = count_r;
    if (dec_push) begin
      wptr_nxt = wptr_r + 1'b1;
      if (count_r != pdoc_pkg::CNT_W'(pdoc_pkg::HIST_DEPTH)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdoc_pkg::ST_ACCEPT;
      tok_r       <= pdoc_pkg::TOK_IDLE;
      lit_left_r  <= '0;
      pair_hi_r   <= '0;
      wptr_r      <= '0;
      count_r     <= '0;
      copy_left_r <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      copy_left_r <= copy_left_nxt;
      last_r      <= last_nxt;
      if (clear) begin
        tok_r      <= pdoc_pkg::TOK_IDLE;
        lit_left_r <= '0;
        pair_hi_r  <= '0;
        wptr_r     <= '0;
        count_r    <= '0;
      end else begin
        tok_r      <= tok_nxt;
        lit_left_r <= lit_left_nxt;
        pair_hi_r  <= pair_hi_nxt;
        wptr_r     <= wptr_nxt;
        count_r    <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    hold_r <= hold_nxt;
    if (hist_rd.en) begin
      byp_r      <= hist_wr.en && (hist_wr.addr == hist_rd.addr);
      byp_data_r <= hist_wr.data;
    end
  end

endmodule

// ----- rtl/core/palmdoc_decompressor.sv -----
// PalmDoc LZ77 record decompressor.
// Input channel (in_valid/in_ready/in_data): one compressed byte per beat,
// with last_in set on the record's final byte. Output channel
// (out_valid/out_ready/out_data): one decoded byte per beat, with run_last on
// the last beat caused by an input, record_end on the last beat of the
// record, and an error code (bad distance, or record truncated mid-token).
// A result is in the output register in the cycle after the input beat
// that causes it is taken; the first copied byte of a back-reference goes
// through the history RAM's read register and then the output register.
// A space-pair byte or a back-reference second byte holds off the input
// until its space and flipped byte, or its copy (length 3 to 10), is out;
// the history RAM delivers one copied byte per cycle while the output
// register can take it, with the just-written byte forwarded for a distance
// of one. Opening bytes of a run or back-reference produce no decoded byte.
// Reset clears the decode state and the history pointer; the history RAM
// itself is not cleared. A stalled receiver holds the output register and
// the decoder freezes behind it; no beat is dropped.
module palmdoc_decompressor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdoc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pdoc_pkg::out_beat_t out_data
);

  logic                res_valid;
  logic                res_ready;
  pdoc_pkg::out_beat_t res_data;
  pdoc_pkg::hist_wr_t  hist_wr;
  pdoc_pkg::hist_rd_t  hist_rd;
  logic [7:0]          hist_rdata;
  logic                out_valid_r;
  pdoc_pkg::out_beat_t out_data_r;

  assign res_ready = !out_valid_r || out_ready;

  pdoc_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .hist_wr    (hist_wr),
    .hist_rd    (hist_rd),
    .hist_rdata (hist_rdata)
  );

  pdoc_hist_ram #(
    .AW (pdoc_pkg::HIST_AW),
    .DW (8)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_wr.en),
    .waddr (hist_wr.addr),
    .wdata (hist_wr.data),
    .re    (hist_rd.en),
    .raddr (hist_rd.addr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_BEATS   = 60;
  localparam int MAX_REACH      = pdoc_pkg::HIST_DEPTH - 1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pdoc_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  pdoc_pkg::out_beat_t out_data;

  palmdoc_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state as the scoreboard sees it
  pdoc_pkg::tok_mode_t          model_mode = pdoc_pkg::TOK_IDLE;
  logic [3:0]                   model_lit_left = '0;
  logic [5:0]                   model_pair_hi = '0;
  logic [7:0]                   model_hist [pdoc_pkg::HIST_DEPTH];
  logic [pdoc_pkg::HIST_AW-1:0] model_wr_ptr = '0;
  int unsigned                  model_count = 0;
  pdoc_pkg::out_beat_t          pending_decoded [$];

  int unsigned sent_beats = 0;
  int unsigned checked_beats = 0;
  int unsigned records_seen = 0;
  int unsigned dist_errors = 0;
  int unsigned trunc_errors = 0;
  int unsigned fault_count = 0;
  int          quiet_cycles = 0;

  int          gen_count = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  logic [3:0]  holdoff_req = '0;
  logic [3:0]  holdoff_seen = '0;
  int          holdoff_left = 0;
  logic [15:0] recv_cycle = '0;

  function void queue_decoded(input logic [7:0] b, input pdoc_pkg::err_e_t err);
    pdoc_pkg::out_beat_t beat;
    beat = '{out_byte: b, run_last: 1'b0, record_end: 1'b0, error: err};
    pending_decoded.push_back(beat);
  endfunction

  function void record_byte(input logic [7:0] b);
    model_hist[model_wr_ptr] = b;
    model_wr_ptr = model_wr_ptr + 1'b1;
    if (model_count < pdoc_pkg::HIST_DEPTH) model_count++;
    queue_decoded(b, pdoc_pkg::ERR_NONE);
  endfunction

  function void predict_decoded(input pdoc_pkg::in_beat_t beat);
    logic [13:0]                  code;
    logic [pdoc_pkg::HIST_AW-1:0] back_dist;
    logic [pdoc_pkg::HIST_AW-1:0] src;
    int unsigned                  len;
    int                           first;
    int                           i;
    pdoc_pkg::out_beat_t          tail;
    first = pending_decoded.size();
    unique case (model_mode)
      pdoc_pkg::TOK_LIT: begin
        record_byte(beat.in_byte);
        model_lit_left = model_lit_left - 1'b1;
        if (model_lit_left == 4'd0) model_mode = pdoc_pkg::TOK_IDLE;
      end
      pdoc_pkg::TOK_PAIR: begin
        code = {model_pair_hi, beat.in_byte} & pdoc_pkg::CODE_MASK;
        back_dist = code[13:3];
        len = code[2:0] + pdoc_pkg::LEN_BIAS;
        model_mode = pdoc_pkg::TOK_IDLE;
        model_pair_hi = '0;
        if (back_dist == '0 || back_dist > model_count) begin
          queue_decoded(8'h00, pdoc_pkg::ERR_DIST);
        end else begin
          for (i = 0; i < len; i++) begin
            src = model_wr_ptr - back_dist;
            record_byte(model_hist[src]);
          end
        end
      end
      default: begin
        if (beat.in_byte >= 8'd1 && beat.in_byte <= pdoc_pkg::LIT_RUN_MAX) begin
          model_lit_left = beat.in_byte[3:0];
          model_mode = pdoc_pkg::TOK_LIT;
        end else if (beat.in_byte <= pdoc_pkg::PLAIN_MAX) begin
          record_byte(beat.in_byte);
        end else if (beat.in_byte >= pdoc_pkg::SPACE_PAIR_LO) begin
          record_byte(pdoc_pkg::SPACE_CHAR);
          record_byte(beat.in_byte ^ pdoc_pkg::FLIP_MASK);
        end else begin
          model_pair_hi = beat.in_byte[5:0];
          model_mode = pdoc_pkg::TOK_PAIR;
        end
      end
    endcase
    if (beat.last_in) begin
      if (model_mode != pdoc_pkg::TOK_IDLE) queue_decoded(8'h00, pdoc_pkg::ERR_TRUNC);
      model_mode = pdoc_pkg::TOK_IDLE;
      model_lit_left = '0;
      model_pair_hi = '0;
      model_wr_ptr = '0;
      model_count = 0;
      records_seen++;
    end
    if (pending_decoded.size() > first) begin
      tail = pending_decoded.pop_back();
      tail.run_last = 1'b1;
      tail.record_end = beat.last_in;
      pending_decoded.push_back(tail);
    end
  endfunction

  function void flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
    fault_count++;
    $error("%s mismatch: expected %0h, got %0h", field, want, got);
  endfunction

  function void check_decoded(input pdoc_pkg::out_beat_t got);
    pdoc_pkg::out_beat_t want;
    checked_beats++;
    if (got.error == pdoc_pkg::ERR_DIST) dist_errors++;
    if (got.error == pdoc_pkg::ERR_TRUNC) trunc_errors++;
    if (pending_decoded.size() == 0) begin
      fault_count++;
      $error("decoded beat %0h with nothing expected", got);
    end else begin
      want = pending_decoded.pop_front();
      if (got.out_byte !== want.out_byte) flag_field("out_byte", want.out_byte, got.out_byte);
      if (got.run_last !== want.run_last) flag_field("run_last", want.run_last, got.run_last);
      if (got.record_end !== want.record_end)
        flag_field("record_end", want.record_end, got.record_end);
      if (got.error !== want.error) flag_field("error", want.error, got.error);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_decoded(in_data);
      if (out_valid && out_ready) check_decoded(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    recv_cycle <= recv_cycle + 1'b1;
    if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      unique case (recv_cycle[8:6])
        3'd0, 3'd1: out_ready <= 1'b1;
        3'd2, 3'd3: out_ready <= ($urandom_range(0, 3) != 0);
        3'd4:       out_ready <= (recv_cycle[1:0] != 2'd0);
        3'd5:       out_ready <= ($urandom_range(0, 1) == 1);
        default:    out_ready <= (recv_cycle[3:0] < 4'd5);
      endcase
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    if (burst_left <= 0 && !steady) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    in_data <= '{in_byte: b, last_in: fin};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_beats++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = $urandom_range(1, 16);
    do @(posedge clk); while (pending_decoded.size() != 0);
  endtask

  function void gen_grow(input int n);
    gen_count = (gen_count + n > pdoc_pkg::HIST_DEPTH) ? pdoc_pkg::HIST_DEPTH
                                                       : gen_count + n;
  endfunction

  function int gen_reach();
    return (gen_count < MAX_REACH) ? gen_count : MAX_REACH;
  endfunction

  task automatic send_back_ref(input int back_dist, input int len, input logic fin);
    logic [pdoc_pkg::HIST_AW-1:0] d;
    logic [2:0]                   l;
    logic [13:0]                  code;
    d = pdoc_pkg::HIST_AW'(back_dist);
    l = 3'(len - pdoc_pkg::LEN_BIAS);
    code = {d, l};
    send_beat(pdoc_pkg::FLIP_MASK | {2'b00, code[13:8]}, 1'b0);
    send_beat(code[7:0], fin);
    if (back_dist != 0 && back_dist <= gen_count) gen_grow(len);
  endtask

  task automatic send_plain(input logic fin);
    logic [7:0] b;
    b = ($urandom_range(0, 7) == 0)
        ? 8'h00
        : 8'($urandom_range(pdoc_pkg::LIT_RUN_MAX + 1, pdoc_pkg::PLAIN_MAX));
    send_beat(b, fin);
    gen_grow(1);
  endtask

  task automatic send_random_token(input logic fin);
    int         kind;
    int         n;
    int         i;
    int         back_dist;
    int         reach;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    reach = gen_reach();
    if (kind >= 6 && reach > 0) begin
      if ($urandom_range(0, 11) == 0)
        back_dist = (reach == MAX_REACH || $urandom_range(0, 1) == 0)
                    ? 0 : $urandom_range(reach + 1, MAX_REACH);
      else
        back_dist = $urandom_range(1, reach);
      send_back_ref(back_dist, $urandom_range(3, 10), fin);
    end else if (kind == 3 || kind == 4) begin
      n = $urandom_range(1, 8);
      b = 8'(n);
      send_beat(b, 1'b0);
      for (i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), fin && i == n - 1);
      gen_grow(n);
    end else if (kind == 5) begin
      send_beat(8'($urandom_range(pdoc_pkg::SPACE_PAIR_LO, 255)), fin);
      gen_grow(2);
    end else begin
      send_plain(fin);
    end
  endtask

  // end the record inside an open literal run or back-reference
  task automatic send_cut_token();
    int         n;
    int         k;
    int         i;
    logic [7:0] b;
    if ($urandom_range(0, 1) == 1) begin
      n = $urandom_range(1, 8);
      k = $urandom_range(0, n - 1);
      b = 8'(n);
      send_beat(b, k == 0);
      for (i = 0; i < k; i++) send_beat(8'($urandom_range(0, 255)), i == k - 1);
    end else begin
      send_beat(8'($urandom_range(8'h80, 8'hBF)), 1'b1);
    end
  endtask

  task automatic send_record(input int tokens, input bit cut);
    int t;
    gen_count = 0;
    for (t = 0; t < tokens; t++) send_random_token(!cut && t == tokens - 1);
    if (cut) send_cut_token();
    gen_count = 0;
  endtask

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), i == n - 1);
    gen_count = 0;
  endtask

  task automatic test_plain_bytes();
    send_beat(8'h00, 1'b0);
    send_beat(8'h09, 1'b0);
    send_beat(8'h7F, 1'b1);
  endtask

  task automatic test_literal_runs();
    send_beat(8'h01, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h02, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b1);
  endtask

  task automatic test_space_pairs();
    send_beat(8'hC0, 1'b0);
    send_beat(8'hFF, 1'b1);
  endtask

  task automatic test_back_refs();
    send_beat(8'h41, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h0B, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h17, 1'b1);
  endtask

  task automatic test_bad_distances();
    send_beat(8'h42, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h09, 1'b1);
  endtask

  task automatic test_truncation();
    send_beat(8'h03, 1'b0);
    send_beat(8'h41, 1'b1);
    send_beat(8'h08, 1'b1);
    send_beat(8'h85, 1'b1);
  endtask

  // hold the receiver off and keep offering beats until the input stalls
  task automatic test_backpressure();
    int i;
    holdoff_req <= holdoff_req + 1'b1;
    steady = 1'b1;
    gen_count = 0;
    for (i = 0; i < 4; i++) send_plain(1'b0);
    for (i = 0; i < 10; i++) send_back_ref($urandom_range(1, gen_reach()), 10, i == 9);
    steady = 1'b0;
    gen_count = 0;
    wait_drained();
  endtask

  task automatic test_history_wrap();
    int r;
    int back_dist;
    gen_count = 0;
    for (r = 0; r < 3; r++) send_plain(1'b0);
    for (r = 0; r < 230; r++) begin
      back_dist = (r % 16 == 15) ? gen_reach() : $urandom_range(1, gen_reach());
      send_back_ref(back_dist, (r % 5 == 0) ? $urandom_range(3, 10) : 10, 1'b0);
    end
    send_plain(1'b1);
    gen_count = 0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int          pick;
    start = sent_beats;
    while (sent_beats - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) send_noise($urandom_range(1, 12));
      else send_record($urandom_range(1, 24), pick < 6);
      if (pick == 19) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_literal_runs();
    test_space_pairs();
    test_back_refs();
    test_bad_distances();
    test_truncation();
    test_backpressure();
    test_history_wrap();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d compressed beats in %0d records, %0d decoded beats checked",
             sent_beats, records_seen, checked_beats);
    $display("with %0d bad-distance and %0d truncation beats, history wrap and stalls",
             dist_errors, trunc_errors);
    if (pending_decoded.size() != 0)
      $error("%0d decoded beats never arrived", pending_decoded.size());
    if (fault_count == 0 && pending_decoded.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pdoc_pkg.sv
rtl/core/pdoc_hist_ram.sv
rtl/core/pdoc_decoder.sv
rtl/core/palmdoc_decompressor.sv
sim/tb_top.sv
